/* hw/rtl/assert_macros.svh */
// assertion macros shared by the seven-segment scan driver rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define SSD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ssd assertion failed");

// same-cycle implication
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// next-cycle implication
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`endif

/* hw/rtl/ssd_pkg.sv */
// types, constants and segment table for the seven-segment scan driver
// no dependencies; imported by ssd_front, ssd_back and the top level
`default_nettype none

package ssd_pkg;

    localparam int VALUE_W     = 27;
    localparam int POINT_W     = 4;
    localparam int DIGIT_W     = 4;
    localparam int NUM_STORE   = 8;
    localparam int SCAN_W      = 3;
    localparam int PHASE_W     = 5;
    localparam int DWELL_W     = 8;
    localparam int SEL_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CONV_W      = $clog2(NUM_STORE);
    localparam int RECIP_W     = 28;
    localparam int DIV10_SHIFT = 31;
    localparam int PROD_W      = VALUE_W + DIV10_SHIFT;

    localparam logic                KIND_LOAD    = 1'b1;
    localparam logic [PHASE_W-1:0]  PH_LATCH_HI  = 5'd16;
    localparam logic [PHASE_W-1:0]  PH_LATCH_LO  = 5'd17;
    localparam logic [PHASE_W-1:0]  PH_DWELL     = 5'd18;
    localparam logic [DWELL_W-1:0]  DWELL_RESET  = 8'd1;
    localparam logic [CONV_W-1:0]   CONV_LAST    = CONV_W'(NUM_STORE - 2);
    // ceil(2^31 / 10), exact quotient for any value below 2^27
    localparam logic [RECIP_W-1:0]  DIV10_RECIP  = 28'd214748365;

    typedef struct packed {
        logic               is_load;
        logic [VALUE_W-1:0] value;
        logic [POINT_W-1:0] point;
    } t_cmd;

    typedef enum logic {
        BK_RUN,
        BK_CONV
    } t_back_state;

    function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        unique case (d)
            4'd0:    c = 8'hFC;
            4'd1:    c = 8'h60;
            4'd2:    c = 8'hDA;
            4'd3:    c = 8'hF2;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'hB6;
            4'd6:    c = 8'hBE;
            4'd7:    c = 8'hE0;
            4'd8:    c = 8'hFE;
            4'd9:    c = 8'hF6;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssd_front.sv */
// front end: accepts input words, classifies tick or load, queues commands
// depends on ssd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ssd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_kind,
    input  wire logic [ssd_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ssd_pkg::POINT_W-1:0] i_point_position,
    output ssd_pkg::t_cmd                    o_cmd,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_pop
);
    import ssd_pkg::*;

    t_cmd                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;
    logic                push;
    logic                pop;
    t_cmd                in_cmd;

    assign o_stall     = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        in_cmd.is_load = (i_kind == KIND_LOAD);
        in_cmd.value   = i_value;
        in_cmd.point   = i_point_position;
        n_count        = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    `SSD_ASSERT_NEXT(a_count_drops, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

/* hw/rtl/ssd_back.sv */
// back end: binary to decimal conversion, digit store and scan sequencer
// depends on ssd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ssd_back #(
    parameter int NUM_DIGITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssd_pkg::t_cmd               i_cmd,
    input  wire logic                        i_cmd_valid,
    output logic                             o_pop,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ssd_pkg::DWELL_W-1:0] i_cfg_wr_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_serial_data,
    output logic                             o_shift_clock,
    output logic                             o_latch_clock,
    output logic [ssd_pkg::SEL_W-1:0]        o_digit_select
);
    import ssd_pkg::*;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [DWELL_W-1:0]  r_dwell_ticks;
    logic [DIGIT_W-1:0]  r_digits [NUM_STORE];
    logic [POINT_W-1:0]  r_point;
    logic [SCAN_W-1:0]   r_scan;
    logic [SCAN_W-1:0]   n_scan;
    logic [PHASE_W-1:0]  r_phase;
    logic [PHASE_W-1:0]  n_phase;
    logic [DWELL_W-1:0]  r_dwell_cnt;
    logic [DWELL_W-1:0]  n_dwell_cnt;
    logic [VALUE_W-1:0]  r_bin;
    logic [CONV_W-1:0]   r_conv_cnt;
    logic [POINT_W-1:0]  r_point_pend;
    logic                r_out_valid;
    logic                r_out_data;
    logic                r_out_sclk;
    logic                r_out_lclk;
    logic [SEL_W-1:0]    r_out_sel;

    logic                can_out;
    logic                tick_fire;
    logic                load_fire;
    logic [SCAN_W-1:0]   cur_scan;
    logic [PHASE_W-1:0]  cur_phase;
    logic [SCAN_W:0]     scan_inc;
    logic [SCAN_W-1:0]   scan_wrap;
    logic [7:0]          code;
    logic [DWELL_W-1:0]  dwell_dec;
    logic                t_data;
    logic                t_sclk;
    logic                t_lclk;
    logic [SEL_W-1:0]    t_sel;
    logic [VALUE_W-1:0]  div_quot;
    logic [DIGIT_W-1:0]  div_rem;

    assign can_out   = !r_out_valid || !i_stall;
    assign o_pop     = (r_state == BK_RUN) && i_cmd_valid && (i_cmd.is_load || can_out);
    assign tick_fire = o_pop && !i_cmd.is_load;
    assign load_fire = o_pop && i_cmd.is_load;

    assign o_valid        = r_out_valid;
    assign o_serial_data  = r_out_data;
    assign o_shift_clock  = r_out_sclk;
    assign o_latch_clock  = r_out_lclk;
    assign o_digit_select = r_out_sel;

    // one decimal digit per clock: reciprocal multiply, remainder by shift-add
    always_comb begin
        div_quot = VALUE_W'((PROD_W'(r_bin) * PROD_W'(DIV10_RECIP)) >> DIV10_SHIFT);
        div_rem  = DIGIT_W'(r_bin - ({div_quot[VALUE_W-4:0], 3'b000} +
                                     {div_quot[VALUE_W-2:0], 1'b0}));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (load_fire) begin
                    n_state = BK_CONV;
                end
            end
            BK_CONV: begin
                if (r_conv_cnt == CONV_LAST) begin
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    // scan sequencer for one tick
    always_comb begin
        if (({1'b0, r_scan} >= (SCAN_W+1)'(NUM_DIGITS))) begin
            cur_scan  = '0;
            cur_phase = '0;
        end else begin
            cur_scan  = r_scan;
            cur_phase = r_phase;
        end
        scan_inc  = {1'b0, cur_scan} + 1'b1;
        scan_wrap = (scan_inc >= (SCAN_W+1)'(NUM_DIGITS) || scan_inc[SCAN_W]) ?
                    '0 : scan_inc[SCAN_W-1:0];
        t_sel     = SEL_W'(3'd7 - cur_scan);
        code      = seg_code(r_digits[cur_scan]);
        if (r_point == POINT_W'(scan_inc)) begin
            code[0] = 1'b1;
        end
        dwell_dec   = (r_dwell_cnt != '0) ? r_dwell_cnt - 1'b1 : '0;
        t_data      = 1'b0;
        t_sclk      = 1'b0;
        t_lclk      = 1'b0;
        n_scan      = cur_scan;
        n_phase     = cur_phase;
        n_dwell_cnt = r_dwell_cnt;
        priority if (cur_phase < PH_LATCH_HI) begin
            t_data  = code[cur_phase[3:1]];
            t_sclk  = cur_phase[0];
            n_phase = cur_phase + 1'b1;
        end else if (cur_phase == PH_LATCH_HI) begin
            t_lclk  = 1'b1;
            n_phase = PH_LATCH_LO;
        end else if (cur_phase == PH_LATCH_LO) begin
            if (r_dwell_ticks == '0) begin
                n_scan      = scan_wrap;
                n_phase     = '0;
                n_dwell_cnt = '0;
            end else begin
                n_dwell_cnt = r_dwell_ticks;
                n_phase     = PH_DWELL;
            end
        end else if (cur_phase == PH_DWELL) begin
            n_dwell_cnt = dwell_dec;
            if (dwell_dec == '0) begin
                n_scan  = scan_wrap;
                n_phase = '0;
            end
        end else begin
            n_scan      = scan_wrap;
            n_phase     = '0;
            n_dwell_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
            r_point       <= '0;
            r_scan        <= '0;
            r_phase       <= '0;
            r_dwell_cnt   <= '0;
            r_out_valid   <= 1'b0;
            r_conv_cnt    <= '0;
            for (int i = 0; i < NUM_STORE; i++) begin
                r_digits[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_dwell_ticks <= i_cfg_wr_data;
            end
            if (tick_fire) begin
                r_scan      <= n_scan;
                r_phase     <= n_phase;
                r_dwell_cnt <= n_dwell_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load_fire) begin
                r_conv_cnt <= '0;
            end else if (r_state == BK_CONV) begin
                r_conv_cnt           <= r_conv_cnt + 1'b1;
                r_digits[r_conv_cnt] <= div_rem;
                if (r_conv_cnt == CONV_LAST) begin
                    r_digits[NUM_STORE-1] <= div_quot[DIGIT_W-1:0];
                    r_point               <= r_point_pend;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_out_data <= t_data;
            r_out_sclk <= t_sclk;
            r_out_lclk <= t_lclk;
            r_out_sel  <= t_sel;
        end
        if (load_fire) begin
            r_bin        <= i_cmd.value;
            r_point_pend <= i_cmd.point;
        end else if (r_state == BK_CONV) begin
            r_bin <= div_quot;
        end
    end

    `SSD_ASSERT_IMPL(a_no_pop_in_conv, i_clk, i_rst_n, r_state == BK_CONV, !o_pop)
    `SSD_ASSERT_IMPL(a_dwell_nonzero, i_clk, i_rst_n, r_phase == PH_DWELL, r_dwell_cnt != '0)
    `SSD_ASSERT_ALWAYS(a_phase_range, i_clk, i_rst_n, r_phase <= PH_DWELL)

endmodule

`default_nettype wire

/* hw/rtl/seven_segment_scan_driver_core.sv */
// top level of the seven-segment scan driver: front queue and back sequencer
// depends on ssd_pkg, ssd_front and ssd_back
//
//  channel   handshake                data
//  input     i_valid / o_stall        i_kind, i_value, i_point_position
//  output    o_valid / i_stall        o_serial_data, o_shift_clock, o_latch_clock,
//                                     o_digit_select
//  config    i_cfg_wr_en              i_cfg_wr_data (dwell_ticks)
//
// a tick word yields one output word and the sequencer takes one tick per clock
// unless the output stalls; a load word holds the sequencer while it is taken and
// its value is split into decimal digits, one per clock; a 4-entry queue keeps the
// input open meanwhile. reset is synchronous, active low, needs no clearing pass
// output stall holds the output register; ticks behind it wait in the queue
`default_nettype none

module seven_segment_scan_driver_core #(
    parameter int NUM_DIGITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_kind,
    input  wire logic [ssd_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ssd_pkg::POINT_W-1:0] i_point_position,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ssd_pkg::DWELL_W-1:0] i_cfg_wr_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_serial_data,
    output logic                             o_shift_clock,
    output logic                             o_latch_clock,
    output logic [ssd_pkg::SEL_W-1:0]        o_digit_select
);
    import ssd_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    ssd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .i_point_position (i_point_position),
        .o_cmd            (cmd),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop)
    );

    ssd_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_pop          (cmd_pop),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_data  (o_serial_data),
        .o_shift_clock  (o_shift_clock),
        .o_latch_clock  (o_latch_clock),
        .o_digit_select (o_digit_select)
    );

endmodule

`default_nettype wire
